// ----- rtl/assert_macros.svh -----
// Assertion macros used by the RTL datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge of clk, skipped while arst_n is low.
`define LPIU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same check, also evaluated while reset is asserted.
`define LPIU_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/lpiu_pkg.sv -----
package lpiu_pkg;

	localparam int LENGTH_BITS_DEF = 5;
	localparam int BYTE_W = 8;
	localparam int REC_W = 16;
	localparam int REC_OUT_W = 17;
	localparam int IDX_W = 11;
	localparam int VAL_W = 31;
	localparam int MAX_RES = 2;
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 64;
	localparam logic [IDX_W-1:0] IDX_MAX = '1;

	typedef enum logic [1:0] {
		PH_LEN,
		PH_VAL,
		PH_STOP
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_FLUSH
	} ctrl_state_t;

	typedef struct packed {
		logic load_byte;
		logic shift_bit;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic bit_last;
		logic ob_empty;
	} sts_t;

	typedef struct packed {
		logic [VAL_W-1:0] val;
		logic [IDX_W-1:0] idx;
		logic [REC_OUT_W-1:0] rec;
	} res_t;

endpackage

// ----- rtl/lpiu_ctrl.sv -----
module lpiu_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  lpiu_pkg::sts_t sts,
	output lpiu_pkg::cmd_t cmd,
	output logic           in_ready
);

	lpiu_pkg::ctrl_state_t state_q;
	lpiu_pkg::ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpiu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		in_ready      = 1'b0;
		unique case (state_q)
			lpiu_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.load_byte = in_valid;
				if (in_valid) begin
					state_d = lpiu_pkg::ST_SHIFT;
				end
			end
			lpiu_pkg::ST_SHIFT: begin
				cmd.shift_bit = 1'b1;
				if (sts.bit_last) begin
					state_d = lpiu_pkg::ST_FLUSH;
				end
			end
			lpiu_pkg::ST_FLUSH: begin
				if (sts.ob_empty) begin
					cmd.flush = 1'b1;
					state_d   = lpiu_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lpiu_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/lpiu_datapath.sv -----
`include "assert_macros.svh"

module lpiu_datapath #(
	parameter int LENGTH_BITS = lpiu_pkg::LENGTH_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lpiu_pkg::cmd_t                  cmd,
	output lpiu_pkg::sts_t                  sts,
	input  logic [lpiu_pkg::BYTE_W-1:0]     in_byte,
	input  logic [lpiu_pkg::REC_W-1:0]      in_rec,
	input  logic                            in_last,
	output logic                            out_valid,
	input  logic                            out_ready,
	output lpiu_pkg::res_t                  out_res,
	output logic                            out_last
);

	localparam int MAX_N = (1 << LENGTH_BITS) - 1;
	localparam int AW = (MAX_N > lpiu_pkg::VAL_W) ? MAX_N : lpiu_pkg::VAL_W;
	localparam int CNT_W = $clog2(lpiu_pkg::BYTE_W);
	localparam logic signed [AW-1:0] VMAX =
		{{(AW - lpiu_pkg::VAL_W + 1){1'b0}}, {(lpiu_pkg::VAL_W - 1){1'b1}}};
	localparam logic signed [AW-1:0] VMIN =
		{{(AW - lpiu_pkg::VAL_W + 1){1'b1}}, {(lpiu_pkg::VAL_W - 1){1'b0}}};

	// Per-byte input registers.
	logic [lpiu_pkg::BYTE_W-1:0]    byte_q;
	logic [lpiu_pkg::REC_OUT_W-1:0] rec_q;
	logic                           last_q;
	logic [CNT_W-1:0]               bit_cnt_q;

	// Bit-serial decoder state.
	lpiu_pkg::phase_t               phase_q;
	logic [LENGTH_BITS-1:0]         flen_q;
	logic [LENGTH_BITS-1:0]         seen_q;
	logic signed [AW-1:0]           acc_q;
	logic [lpiu_pkg::IDX_W-1:0]     count_q;

	// Results completed within the current byte.
	lpiu_pkg::res_t                 slot_q [lpiu_pkg::MAX_RES];
	logic [1:0]                     nres_q;

	// Output buffer, drained while the next byte is decoded.
	lpiu_pkg::res_t                 ob_q [lpiu_pkg::MAX_RES];
	logic                           ob_valid_q;
	logic                           ob_two_q;
	logic                           ob_ptr_q;

	logic                           cur_bit;
	logic [LENGTH_BITS:0]           seen_inc;
	logic signed [AW-1:0]           acc_next;
	logic                           len_done;
	logic                           val_done;
	logic [lpiu_pkg::IDX_W-1:0]     count_next;
	logic [lpiu_pkg::VAL_W-1:0]     val_sat;
	logic                           out_xfer;

	assign cur_bit    = byte_q[lpiu_pkg::BYTE_W-1];
	assign seen_inc   = {1'b0, seen_q} + 1'b1;
	assign acc_next   = (seen_q == '0) ? {AW{cur_bit}} : {acc_q[AW-2:0], cur_bit};
	assign len_done   = (seen_inc == (LENGTH_BITS + 1)'(LENGTH_BITS));
	assign val_done   = (seen_inc == {1'b0, flen_q});
	assign count_next = (count_q == lpiu_pkg::IDX_MAX) ? count_q : count_q + 1'b1;

	always_comb begin
		priority if (acc_next > VMAX) begin
			val_sat = VMAX[lpiu_pkg::VAL_W-1:0];
		end else if (acc_next < VMIN) begin
			val_sat = VMIN[lpiu_pkg::VAL_W-1:0];
		end else begin
			val_sat = acc_next[lpiu_pkg::VAL_W-1:0];
		end
	end

	assign sts.bit_last = (bit_cnt_q == CNT_W'(lpiu_pkg::BYTE_W - 1));
	assign sts.ob_empty = !ob_valid_q;

	assign out_valid = ob_valid_q;
	assign out_res   = ob_q[ob_ptr_q];
	assign out_last  = ob_ptr_q || !ob_two_q;
	assign out_xfer  = ob_valid_q && out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load_byte) begin
			byte_q <= in_byte;
			rec_q  <= {1'b0, in_rec} + 1'b1;
			last_q <= in_last;
		end else if (cmd.shift_bit) begin
			byte_q <= {byte_q[lpiu_pkg::BYTE_W-2:0], 1'b0};
		end
		if (cmd.shift_bit && phase_q == lpiu_pkg::PH_VAL && val_done && !nres_q[1]) begin
			slot_q[nres_q[0]] <= '{val: val_sat, idx: count_next, rec: rec_q};
		end
		if (cmd.flush) begin
			ob_q[0] <= slot_q[0];
			ob_q[1] <= slot_q[1];
			ob_two_q <= nres_q[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q  <= '0;
			nres_q     <= '0;
			phase_q    <= lpiu_pkg::PH_LEN;
			flen_q     <= '0;
			seen_q     <= '0;
			acc_q      <= '0;
			count_q    <= '0;
			ob_valid_q <= 1'b0;
			ob_ptr_q   <= 1'b0;
		end else begin
			if (cmd.load_byte) begin
				bit_cnt_q <= '0;
				nres_q    <= '0;
			end
			if (cmd.shift_bit) begin
				bit_cnt_q <= bit_cnt_q + 1'b1;
				if (phase_q == lpiu_pkg::PH_VAL && val_done && !nres_q[1]) begin
					nres_q <= nres_q + 1'b1;
				end
				// The record's last byte clears the decoder once its bits are used.
				if (sts.bit_last && last_q) begin
					phase_q <= lpiu_pkg::PH_LEN;
					flen_q  <= '0;
					seen_q  <= '0;
					acc_q   <= '0;
					count_q <= '0;
				end else begin
					unique case (phase_q)
						lpiu_pkg::PH_LEN: begin
							flen_q <= {flen_q[LENGTH_BITS-2:0], cur_bit};
							if (len_done) begin
								seen_q  <= '0;
								acc_q   <= '0;
								phase_q <= ({flen_q[LENGTH_BITS-2:0], cur_bit} == '0) ?
									lpiu_pkg::PH_STOP : lpiu_pkg::PH_VAL;
							end else begin
								seen_q <= seen_inc[LENGTH_BITS-1:0];
							end
						end
						lpiu_pkg::PH_VAL: begin
							if (val_done) begin
								count_q <= count_next;
								phase_q <= lpiu_pkg::PH_LEN;
								seen_q  <= '0;
								flen_q  <= '0;
								acc_q   <= '0;
							end else begin
								seen_q <= seen_inc[LENGTH_BITS-1:0];
								acc_q  <= acc_next;
							end
						end
						default: begin
						end
					endcase
				end
			end
			if (cmd.flush) begin
				ob_valid_q <= (nres_q != '0);
				ob_ptr_q   <= 1'b0;
			end else if (out_xfer) begin
				if (out_last) begin
					ob_valid_q <= 1'b0;
				end else begin
					ob_ptr_q <= 1'b1;
				end
			end
		end
	end

	`LPIU_ASSERT(a_flush_when_empty, cmd.flush |-> !ob_valid_q,
		"Output buffer overwritten before it was drained.")
	`LPIU_ASSERT(a_val_in_range, phase_q == lpiu_pkg::PH_VAL |-> seen_q < flen_q,
		"Value bit count ran past the field length.")
	`LPIU_ASSERT(a_record_clear,
		cmd.shift_bit && sts.bit_last && last_q |=> phase_q == lpiu_pkg::PH_LEN && count_q == '0,
		"Decoder state not cleared after the last byte of a record.")
	`LPIU_ASSERT(a_slot_bound, nres_q != 2'd3, "More than two results captured for one byte.")

endmodule

// ----- rtl/length_prefixed_int_unpacker.sv -----
// Channel  | Role   | tdata (low bit up)                          | tlast
// s_axis   | input  | stream_byte[7:0], record_number[23:8]        | last_byte
// m_axis   | output | record_out[16:0], integer_index[27:17],      | last_of_run
//          |        | decoded_value[58:28], zero fill[63:59]       |
// A byte is decoded one bit per cycle, so the bit-serial decoder sets the rate:
// load, eight bit shifts and hand-over, before the next byte is taken.
// Up to two results of a byte sit in an output buffer that drains while the next
// byte is decoded; hand-over waits while that buffer still holds results.
// arst_n clears all decoder and handshake state at once; no clearing pass follows.
module length_prefixed_int_unpacker #(
	parameter int LENGTH_BITS = lpiu_pkg::LENGTH_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// stream_byte [7:0], record_number [23:8]
	input  logic [lpiu_pkg::S_DATA_W-1:0] s_axis_tdata,
	input  logic                          s_axis_tlast,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// record_out [16:0], integer_index [27:17], decoded_value [58:28], zeros above
	output logic [lpiu_pkg::M_DATA_W-1:0] m_axis_tdata,
	output logic                          m_axis_tlast
);

	lpiu_pkg::cmd_t cmd;
	lpiu_pkg::sts_t sts;
	lpiu_pkg::res_t res;

	lpiu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.sts      (sts),
		.cmd      (cmd),
		.in_ready (s_axis_tready)
	);

	lpiu_datapath #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_byte   (s_axis_tdata[lpiu_pkg::BYTE_W-1:0]),
		.in_rec    (s_axis_tdata[lpiu_pkg::BYTE_W +: lpiu_pkg::REC_W]),
		.in_last   (s_axis_tlast),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = lpiu_pkg::M_DATA_W'({res.val, res.idx, res.rec});

endmodule
